// ----- src/tpj_pkg.sv -----
// Shared types, constants and helper functions of the turret pose and Jacobian unit.
`default_nettype none

package tpj_pkg;

    // Joint count of the arm; the Jacobian has one column per joint
    localparam int JOINT_COUNT = 3;

    // CORDIC constants in Q.28
    localparam logic signed [31:0] Q28_PI      = 32'sd843314857;
    localparam logic signed [31:0] Q28_HALF_PI = 32'sd421657428;
    localparam logic signed [31:0] Q28_GAIN    = 32'sd163008219;
    localparam int                 ATAN_LEN    = 24;

    // Scale factors that bring every product to Q.40
    localparam logic signed [15:0] TRIG_ONE  = 16'sd16384;  // 1.0 in Q.14
    localparam logic signed [15:0] SCALE_Q28 = 16'sd4096;   // Q.28 -> Q.40
    localparam logic signed [15:0] SCALE_Q26 = 16'sd16384;  // Q.26 -> Q.40
    localparam logic signed [15:0] ONE_Q12   = 16'sd4096;

    // Register map
    localparam logic ADDR_BASE_OFFSET = 1'b0;
    localparam logic signed [15:0] BASE_OFFSET_RESET = 16'sd2048;

    // Function select codes
    localparam logic FUNC_POSE     = 1'b0;
    localparam logic FUNC_JACOBIAN = 1'b1;

    // Matrix extents
    localparam logic [2:0] POSE_LAST_ROW = 3'd2;
    localparam logic [1:0] POSE_LAST_COL = 2'd3;
    localparam logic [2:0] JAC_LAST_ROW  = 3'd5;
    localparam logic [1:0] JAC_LAST_COL  = 2'(JOINT_COUNT - 1);

    // One rotation lane: vector and residual angle, all Q.28
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cordic_lane_t;

    // Per-item side data that travels with the rotation lanes
    typedef struct packed {
        logic              func;
        logic signed [15:0] q3;
        logic              flip1;
        logic              flip2;
    } item_info_t;

    // atan(2^-i) in Q.28, rounded to nearest
    function automatic logic signed [31:0] atan_q28(input int unsigned idx);
        logic signed [31:0] a;
        unique case (idx)
            0:  a = 32'sd210828714;
            1:  a = 32'sd124459457;
            2:  a = 32'sd65760959;
            3:  a = 32'sd33381290;
            4:  a = 32'sd16755422;
            5:  a = 32'sd8385879;
            6:  a = 32'sd4193963;
            7:  a = 32'sd2097109;
            8:  a = 32'sd1048571;
            9:  a = 32'sd524287;
            10: a = 32'sd262144;
            11: a = 32'sd131072;
            12: a = 32'sd65536;
            13: a = 32'sd32768;
            14: a = 32'sd16384;
            15: a = 32'sd8192;
            16: a = 32'sd4096;
            17: a = 32'sd2048;
            18: a = 32'sd1024;
            19: a = 32'sd512;
            20: a = 32'sd256;
            21: a = 32'sd128;
            22: a = 32'sd64;
            23: a = 32'sd32;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

    // One CORDIC micro-rotation toward z = 0
    function automatic cordic_lane_t cordic_rotate(input cordic_lane_t lane,
                                                   input int unsigned sft);
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [31:0] zs;
        cordic_lane_t       r;
        xs = lane.x;
        ys = lane.y;
        zs = lane.z;
        if (zs >= 0)
        begin
            r.x = xs - (ys >>> sft);
            r.y = ys + (xs >>> sft);
            r.z = zs - atan_q28(sft);
        end
        else
        begin
            r.x = xs + (ys >>> sft);
            r.y = ys - (xs >>> sft);
            r.z = zs + atan_q28(sft);
        end
        return r;
    endfunction

    // Undo the half-turn fold and round Q.28 half up to Q.14
    function automatic logic signed [15:0] round_q14(input logic signed [31:0] v,
                                                     input logic flip);
        logic signed [31:0] f;
        logic signed [31:0] s;
        f = flip ? -v : v;
        s = f + 32'sd8192;
        return s[29:14];
    endfunction

endpackage

`default_nettype wire

// ----- src/tpj_cordic_cell.sv -----
// One CORDIC cell: a micro-rotation of both angle lanes, registered toward the next cell.
`default_nettype none

module tpj_cordic_cell #(
    parameter int unsigned STAGE = 0
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         adv,
    input  wire                         in_valid,
    input  wire tpj_pkg::cordic_lane_t  in_lane1,
    input  wire tpj_pkg::cordic_lane_t  in_lane2,
    input  wire tpj_pkg::item_info_t    in_info,
    output logic                        out_valid,
    output tpj_pkg::cordic_lane_t       out_lane1,
    output tpj_pkg::cordic_lane_t       out_lane2,
    output tpj_pkg::item_info_t         out_info
);
    import tpj_pkg::*;

    logic         valid_reg;
    cordic_lane_t lane1_reg;
    cordic_lane_t lane2_reg;
    cordic_lane_t lane1_next;
    cordic_lane_t lane2_next;
    item_info_t   info_reg;

    // rotate both lanes by this cell's fixed step
    always_comb
    begin
        lane1_next = cordic_rotate(in_lane1, STAGE);
        lane2_next = cordic_rotate(in_lane2, STAGE);
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane1_reg <= lane1_next;
            lane2_reg <= lane2_next;
            info_reg  <= in_info;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane1 = lane1_reg;
    assign out_lane2 = lane2_reg;
    assign out_info  = info_reg;

endmodule

`default_nettype wire

// ----- src/tpj_entry_unit.sv -----
// Matrix entry sequencer: walks the entries of one item and forms each value in a multiply pipe.
`default_nettype none

module tpj_entry_unit (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire signed [15:0]           base_offset,
    input  wire                         chain_valid,
    input  wire tpj_pkg::cordic_lane_t  chain_lane1,
    input  wire tpj_pkg::cordic_lane_t  chain_lane2,
    input  wire tpj_pkg::item_info_t    chain_info,
    output logic                        load,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [31:0]                 m_tdata,   // row[2:0], col[4:3], value[24:5], zeros
    output logic                        m_tlast
);
    import tpj_pkg::*;

    // sequencer state
    logic               busy_reg;
    logic [2:0]         row_reg;
    logic [1:0]         col_reg;
    logic               func_reg;
    logic signed [15:0] q3_reg;
    logic signed [15:0] s1_reg;
    logic signed [15:0] c1_reg;
    logic signed [15:0] s2_reg;
    logic signed [15:0] c2_reg;

    // multiply pipe
    logic               va_reg;
    logic               vb_reg;
    logic signed [31:0] p1_reg;
    logic signed [15:0] ca_reg;
    logic               nega_reg;
    logic               nega_b_reg;
    logic signed [15:0] adda_reg;
    logic signed [15:0] addb_reg;
    logic [2:0]         rowa_reg;
    logic [2:0]         rowb_reg;
    logic [1:0]         cola_reg;
    logic [1:0]         colb_reg;
    logic               lasta_reg;
    logic               lastb_reg;
    logic signed [47:0] p2_reg;

    // output register
    logic               out_valid_reg;
    logic [2:0]         out_row_reg;
    logic [1:0]         out_col_reg;
    logic [19:0]        out_value_reg;
    logic               out_last_reg;

    logic               pipe_adv;
    logic               issue;
    logic               at_last;
    logic               seq_free;
    logic [2:0]         last_row;
    logic [1:0]         last_col;
    logic signed [15:0] op_a;
    logic signed [15:0] op_b;
    logic signed [15:0] op_c;
    logic               op_neg;
    logic signed [15:0] op_add;
    logic signed [31:0] p1_next;
    logic signed [47:0] p2_next;
    logic signed [48:0] p2_signed;
    logic signed [48:0] p2_round;
    logic signed [20:0] value_sum;

    // handshake and sequencing
    assign pipe_adv = !out_valid_reg || m_tready;
    assign issue    = busy_reg && pipe_adv;
    assign last_row = (func_reg == FUNC_JACOBIAN) ? JAC_LAST_ROW : POSE_LAST_ROW;
    assign last_col = (func_reg == FUNC_JACOBIAN) ? JAC_LAST_COL : POSE_LAST_COL;
    assign at_last  = (row_reg == last_row) && (col_reg == last_col);
    assign seq_free = !busy_reg || (issue && at_last);
    assign load     = chain_valid && seq_free;

    // operand selection: value = round(+-a*b*c in Q.40 to Q.12) + add
    always_comb
    begin
        op_a   = 16'sd0;
        op_b   = 16'sd0;
        op_c   = 16'sd0;
        op_neg = 1'b0;
        op_add = 16'sd0;
        unique case ({func_reg, row_reg, col_reg})
            {FUNC_POSE, 3'd0, 2'd0}:
            begin
                op_a = c1_reg; op_b = c2_reg; op_c = SCALE_Q28;
            end
            {FUNC_POSE, 3'd0, 2'd1}:
            begin
                op_a = s1_reg; op_b = TRIG_ONE; op_c = SCALE_Q28; op_neg = 1'b1;
            end
            {FUNC_POSE, 3'd0, 2'd2}:
            begin
                op_a = s2_reg; op_b = c1_reg; op_c = SCALE_Q28; op_neg = 1'b1;
            end
            {FUNC_POSE, 3'd0, 2'd3}:
            begin
                op_a = s2_reg; op_b = c1_reg; op_c = q3_reg; op_neg = 1'b1;
            end
            {FUNC_POSE, 3'd1, 2'd0}:
            begin
                op_a = s1_reg; op_b = c2_reg; op_c = SCALE_Q28;
            end
            {FUNC_POSE, 3'd1, 2'd1}:
            begin
                op_a = c1_reg; op_b = TRIG_ONE; op_c = SCALE_Q28;
            end
            {FUNC_POSE, 3'd1, 2'd2}:
            begin
                op_a = s1_reg; op_b = s2_reg; op_c = SCALE_Q28; op_neg = 1'b1;
            end
            {FUNC_POSE, 3'd1, 2'd3}:
            begin
                op_a = s1_reg; op_b = s2_reg; op_c = q3_reg; op_neg = 1'b1;
            end
            {FUNC_POSE, 3'd2, 2'd0}:
            begin
                op_a = s2_reg; op_b = TRIG_ONE; op_c = SCALE_Q28;
            end
            {FUNC_POSE, 3'd2, 2'd2}:
            begin
                op_a = c2_reg; op_b = TRIG_ONE; op_c = SCALE_Q28;
            end
            {FUNC_POSE, 3'd2, 2'd3}:
            begin
                op_a = q3_reg; op_b = c2_reg; op_c = SCALE_Q26; op_add = base_offset;
            end
            {FUNC_JACOBIAN, 3'd0, 2'd0}:
            begin
                op_a = s1_reg; op_b = s2_reg; op_c = q3_reg;
            end
            {FUNC_JACOBIAN, 3'd0, 2'd1}:
            begin
                op_a = c1_reg; op_b = c2_reg; op_c = q3_reg; op_neg = 1'b1;
            end
            {FUNC_JACOBIAN, 3'd0, 2'd2}:
            begin
                op_a = s2_reg; op_b = c1_reg; op_c = SCALE_Q28; op_neg = 1'b1;
            end
            {FUNC_JACOBIAN, 3'd1, 2'd0}:
            begin
                op_a = s2_reg; op_b = c1_reg; op_c = q3_reg; op_neg = 1'b1;
            end
            {FUNC_JACOBIAN, 3'd1, 2'd1}:
            begin
                op_a = s1_reg; op_b = c2_reg; op_c = q3_reg; op_neg = 1'b1;
            end
            {FUNC_JACOBIAN, 3'd1, 2'd2}:
            begin
                op_a = s1_reg; op_b = s2_reg; op_c = SCALE_Q28; op_neg = 1'b1;
            end
            {FUNC_JACOBIAN, 3'd2, 2'd1}:
            begin
                op_a = q3_reg; op_b = s2_reg; op_c = SCALE_Q26; op_neg = 1'b1;
            end
            {FUNC_JACOBIAN, 3'd2, 2'd2}:
            begin
                op_a = c2_reg; op_b = TRIG_ONE; op_c = SCALE_Q28;
            end
            {FUNC_JACOBIAN, 3'd3, 2'd1}:
            begin
                op_a = s1_reg; op_b = TRIG_ONE; op_c = SCALE_Q28;
            end
            {FUNC_JACOBIAN, 3'd4, 2'd1}:
            begin
                op_a = c1_reg; op_b = TRIG_ONE; op_c = SCALE_Q28; op_neg = 1'b1;
            end
            {FUNC_JACOBIAN, 3'd5, 2'd0}:
            begin
                op_add = ONE_Q12;
            end
            default:
            begin
                op_a = 16'sd0;
            end
        endcase
    end

    // arithmetic of the pipe
    assign p1_next   = op_a * op_b;
    assign p2_next   = p1_reg * ca_reg;
    assign p2_signed = nega_b_reg ? -{p2_reg[47], p2_reg} : {p2_reg[47], p2_reg};
    assign p2_round  = p2_signed + (49'sd1 <<< 27);
    assign value_sum = p2_round[48:28] + {{5{addb_reg[15]}}, addb_reg};

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= 3'd0;
            col_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            row_reg  <= 3'd0;
            col_reg  <= 2'd0;
        end
        else if (issue)
        begin
            if (at_last)
                busy_reg <= 1'b0;
            else if (col_reg == last_col)
            begin
                col_reg <= 2'd0;
                row_reg <= row_reg + 3'd1;
            end
            else
                col_reg <= col_reg + 2'd1;
        end
    end

    // trig of the item being walked
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg <= chain_info.func;
            q3_reg   <= chain_info.q3;
            c1_reg   <= round_q14(chain_lane1.x, chain_info.flip1);
            s1_reg   <= round_q14(chain_lane1.y, chain_info.flip1);
            c2_reg   <= round_q14(chain_lane2.x, chain_info.flip2);
            s2_reg   <= round_q14(chain_lane2.y, chain_info.flip2);
        end
    end

    // pipe occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pipe_adv)
        begin
            va_reg        <= issue;
            vb_reg        <= va_reg;
            out_valid_reg <= vb_reg;
        end
    end

    // pipe payload
    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            p1_reg        <= p1_next;
            ca_reg        <= op_c;
            nega_reg      <= op_neg;
            adda_reg      <= op_add;
            rowa_reg      <= row_reg;
            cola_reg      <= col_reg;
            lasta_reg     <= at_last;
            p2_reg        <= p2_next;
            nega_b_reg    <= nega_reg;
            addb_reg      <= adda_reg;
            rowb_reg      <= rowa_reg;
            colb_reg      <= cola_reg;
            lastb_reg     <= lasta_reg;
            out_row_reg   <= rowb_reg;
            out_col_reg   <= colb_reg;
            out_value_reg <= value_sum[19:0];
            out_last_reg  <= lastb_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_value_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- src/turret_pose_and_jacobian_unit.sv -----
// Top level: config register, angle folding, CORDIC cell chain and matrix entry streamer.
// Beat path: input stage, CORDIC cells, sequencer, entry multiply pipe, output register.
// Throughput: one entry beat per cycle while m_tready is high, set by the single entry pipe;
// items have 12 (pose) or 18 (Jacobian) entries; up to CORDIC_STAGES + 1 wait in the chain.
// Reset: rst_n asynchronous, active low; clears all valids, the sequencer and sets
// base_offset to 0.5 (2048 in Q3.12).
`default_nettype none

module turret_pose_and_jacobian_unit #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // first_angle[15:0], second_angle[31:16], extension[47:32]
    input  wire         s_tuser,   // func
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // row[2:0], col[4:3], value[24:5], zeros[31:25]
    output logic        m_tlast
);
    import tpj_pkg::*;

    logic signed [15:0] base_offset_reg;
    logic               cfg_write;

    logic               in_valid_reg;
    cordic_lane_t       in_lane1_reg;
    cordic_lane_t       in_lane2_reg;
    item_info_t         in_info_reg;
    cordic_lane_t       fold1_next;
    cordic_lane_t       fold2_next;
    logic               flip1_next;
    logic               flip2_next;
    logic               chain_adv;
    logic               load;

    logic               valid_w [0:CORDIC_STAGES];
    cordic_lane_t       lane1_w [0:CORDIC_STAGES];
    cordic_lane_t       lane2_w [0:CORDIC_STAGES];
    item_info_t         info_w  [0:CORDIC_STAGES];

    // config register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_offset_reg <= BASE_OFFSET_RESET;
        else if (cfg_write && (paddr[2] == ADDR_BASE_OFFSET))
            base_offset_reg <= pwdata[15:0];
    end

    assign prdata = (paddr[2] == ADDR_BASE_OFFSET) ?
                    {{16{base_offset_reg[15]}}, base_offset_reg} : 32'd0;

    // fold angles beyond a quarter turn by a half turn
    function automatic cordic_lane_t fold_angle(input logic signed [15:0] ang,
                                                output logic flip);
        logic signed [31:0] z;
        cordic_lane_t       l;
        z    = {ang[15], ang, 15'd0};
        flip = 1'b0;
        if (z > Q28_HALF_PI)
        begin
            z    = z - Q28_PI;
            flip = 1'b1;
        end
        else if (z < -Q28_HALF_PI)
        begin
            z    = z + Q28_PI;
            flip = 1'b1;
        end
        l.x = Q28_GAIN;
        l.y = 32'sd0;
        l.z = z;
        return l;
    endfunction

    always_comb
    begin
        fold1_next = fold_angle(s_tdata[15:0], flip1_next);
        fold2_next = fold_angle(s_tdata[31:16], flip2_next);
    end

    // the whole chain moves together unless its tail waits on the sequencer
    assign chain_adv = !valid_w[CORDIC_STAGES] || load;
    assign s_tready  = chain_adv;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (chain_adv)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (chain_adv)
        begin
            in_lane1_reg      <= fold1_next;
            in_lane2_reg      <= fold2_next;
            in_info_reg.func  <= s_tuser;
            in_info_reg.q3    <= s_tdata[47:32];
            in_info_reg.flip1 <= flip1_next;
            in_info_reg.flip2 <= flip2_next;
        end
    end

    assign valid_w[0] = in_valid_reg;
    assign lane1_w[0] = in_lane1_reg;
    assign lane2_w[0] = in_lane2_reg;
    assign info_w[0]  = in_info_reg;

    // CORDIC cell chain
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        tpj_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (chain_adv),
            .in_valid  (valid_w[g]),
            .in_lane1  (lane1_w[g]),
            .in_lane2  (lane2_w[g]),
            .in_info   (info_w[g]),
            .out_valid (valid_w[g+1]),
            .out_lane1 (lane1_w[g+1]),
            .out_lane2 (lane2_w[g+1]),
            .out_info  (info_w[g+1])
        );
    end

    // entry streamer
    tpj_entry_unit u_entry (
        .clk         (clk),
        .rst_n       (rst_n),
        .base_offset (base_offset_reg),
        .chain_valid (valid_w[CORDIC_STAGES]),
        .chain_lane1 (lane1_w[CORDIC_STAGES]),
        .chain_lane2 (lane2_w[CORDIC_STAGES]),
        .chain_info  (info_w[CORDIC_STAGES]),
        .load        (load),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // an accepted beat lands in the input stage
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted beat not captured");

    // the tail of the chain holds while the sequencer is busy
    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_w[CORDIC_STAGES] && !load |=> valid_w[CORDIC_STAGES])
        else $error("chain tail dropped an item");

    // the last beat of a matrix sits on its bottom-right entry
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |->
            (m_tdata[2:0] == POSE_LAST_ROW && m_tdata[4:3] == POSE_LAST_COL) ||
            (m_tdata[2:0] == JAC_LAST_ROW && m_tdata[4:3] == JAC_LAST_COL))
        else $error("last flag on wrong entry");

endmodule

`default_nettype wire

// ----- bench/turret_pose_and_jacobian_unit_tb.sv -----
// Self-checking bench for the turret pose and Jacobian unit: stream stimulus and entry scoreboard.
module turret_pose_and_jacobian_unit_tb;

    import tpj_pkg::*;

    localparam int unsigned STAGES       = 16;
    localparam int          ATAN_ENTRIES = 24;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SETTLE_CYCLES = 30;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int          PHASE_ITEMS   = 93;

    // Register addresses (byte address = 4 * index)
    localparam logic [2:0] BASE_OFFSET_ADDR = {ADDR_BASE_OFFSET, 2'b00};
    localparam logic [2:0] SPARE_ADDR       = 3'd4;

    // Rotation constants in Q.28
    localparam longint PI_Q28      = 64'sd843314857;
    localparam longint HALF_PI_Q28 = 64'sd421657428;
    localparam longint GAIN_Q28    = 64'sd163008219;
    localparam longint ARCTAN_Q28 [ATAN_ENTRIES] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    typedef struct {
        logic               func;
        logic signed [15:0] first_angle;
        logic signed [15:0] second_angle;
        logic signed [15:0] extension;
    } joint_item_t;

    typedef struct {
        logic [2:0]  row;
        logic [1:0]  col;
        logic [19:0] value;
        logic        last;
    } matrix_entry_t;

    // Kinematics predictor plus the queue of entries still due from the block
    class kinematics_checker;
        logic signed [15:0] base_offset;
        matrix_entry_t      entries_due[$];
        int unsigned        errors;
        int unsigned        entries_checked;
        int unsigned        pose_items;
        int unsigned        jacobian_items;

        function new();
            base_offset     = BASE_OFFSET_RESET;
            errors          = 0;
            entries_checked = 0;
            pose_items      = 0;
            jacobian_items  = 0;
        endfunction

        function longint round_half_up(input longint v, input int sh);
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        // sin and cos of a Q2.13 angle, both Q.14
        function void trig_pair(input logic signed [15:0] ang,
                                output longint sn, output longint cs);
            longint z;
            longint x;
            longint y;
            longint nx;
            bit     flip;
            int     n;
            z    = longint'(ang) * 32768;
            x    = GAIN_Q28;
            y    = 0;
            flip = 1'b0;
            n    = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;
            // fold into +-pi/2, undo by negating both outputs
            if (z > HALF_PI_Q28)
            begin
                z    = z - PI_Q28;
                flip = 1'b1;
            end
            else if (z < -HALF_PI_Q28)
            begin
                z    = z + PI_Q28;
                flip = 1'b1;
            end
            for (int i = 0; i < n; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ARCTAN_Q28[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ARCTAN_Q28[i];
                end
                x = nx;
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            cs = round_half_up(x, 14);
            sn = round_half_up(y, 14);
        endfunction

        // Accepted input beat: queue every entry it must produce
        function void note_item(input joint_item_t it);
            longint        s1;
            longint        c1;
            longint        s2;
            longint        c2;
            longint        q3;
            longint        m [6][4];
            int            rows;
            int            cols;
            matrix_entry_t ent;
            trig_pair(it.first_angle, s1, c1);
            trig_pair(it.second_angle, s2, c2);
            q3 = longint'(it.extension);
            foreach (m[r, c])
                m[r][c] = 0;
            if (it.func == FUNC_POSE)
            begin
                pose_items++;
                rows = 3;
                cols = 4;
                m[0][0] = round_half_up(c1 * c2, 16);
                m[0][1] = round_half_up(-s1, 2);
                m[0][2] = round_half_up(-s2 * c1, 16);
                m[0][3] = round_half_up(-q3 * s2 * c1, 28);
                m[1][0] = round_half_up(s1 * c2, 16);
                m[1][1] = round_half_up(c1, 2);
                m[1][2] = round_half_up(-s1 * s2, 16);
                m[1][3] = round_half_up(-q3 * s1 * s2, 28);
                m[2][0] = round_half_up(s2, 2);
                m[2][2] = round_half_up(c2, 2);
                m[2][3] = round_half_up(q3 * c2, 14) + longint'(base_offset);
            end
            else
            begin
                jacobian_items++;
                rows = 6;
                cols = JOINT_COUNT;
                m[0][0] = round_half_up(q3 * s1 * s2, 28);
                m[0][1] = round_half_up(-q3 * c1 * c2, 28);
                m[0][2] = round_half_up(-s2 * c1, 16);
                m[1][0] = round_half_up(-q3 * s2 * c1, 28);
                m[1][1] = round_half_up(-q3 * s1 * c2, 28);
                m[1][2] = round_half_up(-s1 * s2, 16);
                m[2][1] = round_half_up(-q3 * s2, 14);
                m[2][2] = round_half_up(c2, 2);
                m[3][1] = round_half_up(s1, 2);
                m[4][1] = round_half_up(-c1, 2);
                m[5][0] = longint'(ONE_Q12);
            end
            for (int r = 0; r < rows; r++)
            begin
                for (int c = 0; c < cols; c++)
                begin
                    ent.row   = 3'(r);
                    ent.col   = 2'(c);
                    ent.value = 20'(m[r][c]);
                    ent.last  = (r == rows - 1) && (c == cols - 1);
                    entries_due.push_back(ent);
                end
            end
        endfunction

        // Accepted result beat against the oldest entry due
        function void check_entry(input logic [31:0] beat, input logic tlast);
            matrix_entry_t exp_ent;
            logic [2:0]    got_row;
            logic [1:0]    got_col;
            logic [19:0]   got_value;
            got_row   = beat[2:0];
            got_col   = beat[4:3];
            got_value = beat[24:5];
            if (entries_due.size() == 0)
            begin
                $error("unexpected entry beat: row %0d col %0d value %0d",
                       got_row, got_col, $signed(got_value));
                errors++;
                return;
            end
            exp_ent = entries_due.pop_front();
            entries_checked++;
            if (got_row !== exp_ent.row)
            begin
                $error("row: expected %0d, actual %0d", exp_ent.row, got_row);
                errors++;
            end
            if (got_col !== exp_ent.col)
            begin
                $error("col: expected %0d, actual %0d", exp_ent.col, got_col);
                errors++;
            end
            if (got_value !== exp_ent.value)
            begin
                $error("value: expected %0d, actual %0d",
                       $signed(exp_ent.value), $signed(got_value));
                errors++;
            end
            if (tlast !== exp_ent.last)
            begin
                $error("last: expected %0d, actual %0d", exp_ent.last, tlast);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // first_angle[15:0], second_angle[31:16], extension[47:32]
    logic        s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // row[2:0], col[4:3], value[24:5], zeros[31:25]
    logic        m_tlast;

    kinematics_checker sb;
    bit                hold_request = 1'b0;
    int                sender_calm   = 0;
    int                receiver_calm = 0;

    turret_pose_and_jacobian_unit #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    // Idle cycles before the next beat; now and then a stretch with none
    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left = 24;
        return $urandom_range(0, 4);
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == BASE_OFFSET_ADDR)
            sb.base_offset = data[15:0];
    endtask

    task automatic send_item(input joint_item_t it);
        int gap;
        gap = draw_gap(sender_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.extension, it.second_angle, it.first_angle};
        s_tuser  <= it.func;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_item(it);
    endtask

    task automatic send_joints(input logic func, input int a1, input int a2, input int ext);
        joint_item_t it;
        it.func         = func;
        it.first_angle  = 16'(a1);
        it.second_angle = 16'(a2);
        it.extension    = 16'(ext);
        send_item(it);
    endtask

    // Mostly in-range angles, some raw patterns beyond +-pi
    task automatic send_random_item();
        int a1;
        int a2;
        a1 = ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(0, 51472) - 25736;
        a2 = ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(0, 51472) - 25736;
        send_joints(1'($urandom_range(0, 1)), a1, a2, int'($urandom));
    endtask

    // Block goes idle once every entry due has arrived
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.entries_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = draw_gap(receiver_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            sb.check_entry(m_tdata, m_tlast);
        end
    end

    initial
    begin
        logic signed [15:0] offsets [5];
        sb = new();
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_POSE;
        m_tready <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero pose, range extremes, fold boundary at pi/2, raw extremes
        send_joints(FUNC_POSE, 0, 0, 0);
        send_joints(FUNC_JACOBIAN, 0, 0, 0);
        send_joints(FUNC_POSE, 25736, -25736, 32767);
        send_joints(FUNC_JACOBIAN, -25736, 25736, -32768);
        send_joints(FUNC_POSE, 12867, 12868, 1);
        send_joints(FUNC_JACOBIAN, 12868, -12867, -1);
        send_joints(FUNC_POSE, -12868, 12867, 4096);
        send_joints(FUNC_JACOBIAN, -12867, -12868, -4096);
        send_joints(FUNC_POSE, 32767, -32768, 32767);
        send_joints(FUNC_JACOBIAN, -32768, 32767, -32768);
        send_joints(FUNC_POSE, 21845, -21846, 21845);
        send_joints(FUNC_JACOBIAN, -21846, 21845, -21846);
        send_joints(FUNC_POSE, 1, -1, 12345);
        send_joints(FUNC_JACOBIAN, 6434, 19302, 8192);

        // Write to an unmapped register must leave the offset alone
        wait_idle();
        apb_write(SPARE_ADDR, $urandom);
        send_joints(FUNC_POSE, 3000, -7000, 20000);
        send_joints(FUNC_POSE, -9000, 15000, -20000);

        // Random phases, one per base offset setting
        offsets[0] = 16'sd32767;
        offsets[1] = -16'sd32768;
        offsets[2] = 16'sd0;
        offsets[3] = 16'($urandom);
        offsets[4] = 16'($urandom);
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            apb_write(BASE_OFFSET_ADDR, {{16{offsets[ph][15]}}, offsets[ph]});
            if (ph == 1)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS) send_random_item();
        end

        // Drain and give stray beats time to show up
        s_tvalid <= 1'b0;
        while (sb.entries_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d pose and %0d Jacobian items, %0d entry beats checked",
                 sb.pose_items, sb.jacobian_items, sb.entries_checked);
        $display("Base offsets: reset value, both extremes, zero and two random values");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Timeout: %0d entries still due", sb.entries_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
